/* hw/rtl/smd_pkg.sv */
// ----------------------------------------------------------------------------
// smd_pkg
// Shared command and status types for the sample mean and deviation block.
// ----------------------------------------------------------------------------
package smd_pkg;

   typedef struct packed {
      logic store_wr;
      logic acc_clr;
      logic mean_start;
      logic pass_clr;
      logic pass_rd;
      logic pass_add;
      logic div_start;
      logic sqrt_start;
      logic res_load;
   } smd_cmd_type;

   typedef struct packed {
      logic full;
      logic mean_done;
      logic pass_end;
      logic div_done;
      logic sqrt_done;
   } smd_sts_type;

endpackage

/* hw/rtl/smd_ram.sv */
// ----------------------------------------------------------------------------
// smd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module smd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* hw/rtl/smd_ctrl.sv */
// ----------------------------------------------------------------------------
// smd_ctrl
// Controller: load samples, then mean, squared pass, divide, root, respond.
// ----------------------------------------------------------------------------
module smd_ctrl
   import smd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output smd_cmd_type cmd,
   input  smd_sts_type sts
);

   typedef enum logic [2:0] {
      LOAD, MEAN, PASS, DRAIN, DIV, ROOT, RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [2:0] drain_ff, drain_in;
   logic      acc;

   assign acc       = req_valid && req_ready;
   assign req_ready = (state_ff == LOAD) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      drain_in     = drain_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         LOAD: begin
            if (acc) begin
               cmd.store_wr = !sts.full;
               if (req_last) begin
                  cmd.mean_start = 1'b1;
                  state_in       = MEAN;
               end
            end
         end
         MEAN: begin
            if (sts.mean_done) begin
               cmd.pass_clr = 1'b1;
               state_in     = PASS;
            end
         end
         PASS: begin
            cmd.pass_rd = 1'b1;
            cmd.pass_add = 1'b1;
            drain_in = 3'd4;
            if (sts.pass_end) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            cmd.pass_add = 1'b1;
            drain_in = drain_ff - 3'd1;
            if (drain_ff == 3'd1) begin
               cmd.div_start = 1'b1;
               state_in      = DIV;
            end
         end
         DIV: begin
            if (sts.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ROOT;
            end
         end
         ROOT: begin
            if (sts.sqrt_done) begin
               cmd.res_load = 1'b1;
               cmd.acc_clr  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = LOAD;
            end
         end
         default: state_in = LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         drain_ff     <= drain_in;
      end
   end

endmodule

/* hw/rtl/smd_dp.sv */
// ----------------------------------------------------------------------------
// smd_dp
// Datapath: sample store, running sum, mean divider, squared-deviation pass,
// restoring divider and bit-pair square root.
// ----------------------------------------------------------------------------
module smd_dp
   import smd_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   sample_take,
   input  smd_cmd_type            cmd,
   output smd_sts_type            sts,
   output logic [15:0]            mean,
   output logic [15:0]            spread,
   output logic [10:0]            count,
   output logic                   overflowed
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = SAMPLE_BITS + CW;
   localparam int DW = SAMPLE_BITS + 2;
   localparam int QW = 64;
   localparam int NW = 2 * CW;
   localparam int MIW = $clog2(SW + 1);

   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [SW-1:0]   sum_ff, sum_in;
   logic                   drop_ff, drop_in;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic                   sts_full, sts_mean_done, sts_pass_end;
   logic                   sts_div_done, sts_sqrt_done;

   assign sts = '{full:      sts_full,
                  mean_done: sts_mean_done,
                  pass_end:  sts_pass_end,
                  div_done:  sts_div_done,
                  sqrt_done: sts_sqrt_done};

   assign sts_full = (cnt_ff == CW'(MAX_SAMPLES));

   always_comb begin
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      drop_in = drop_ff;
      if (cmd.acc_clr) begin
         cnt_in  = '0;
         sum_in  = '0;
         drop_in = 1'b0;
      end else if (sample_take) begin
         if (sts_full) begin
            drop_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CW'(1);
            sum_in = sum_ff + SW'($signed(sample));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         drop_ff <= drop_in;
      end
   end

   // mean: restoring divide of |sum| by n, one bit a cycle
   logic [SW-1:0]          mq_ff, mq_in;
   logic [CW:0]            mr_ff, mr_in;
   logic [MIW-1:0]         mi_ff, mi_in;
   logic                   mbusy_ff, mbusy_in, mneg_ff, mneg_in;
   logic signed [SW-1:0]   mean_ff, mean_in;
   logic [CW:0]            mtry;
   logic [CW:0]            mshift;

   assign mshift = {mr_ff[CW-1:0], mq_ff[SW-1]};
   assign mtry   = mshift - {1'b0, cnt_ff};

   always_comb begin
      mq_in = mq_ff; mr_in = mr_ff; mi_in = mi_ff;
      mbusy_in = mbusy_ff; mneg_in = mneg_ff; mean_in = mean_ff;
      sts_mean_done = 1'b0;
      if (cmd.mean_start) begin
         mneg_in  = sum_in[SW-1];
         mq_in    = sum_in[SW-1] ? SW'(-sum_in) : SW'(sum_in);
         mr_in    = '0;
         mi_in    = '0;
         mbusy_in = 1'b1;
      end else if (mbusy_ff) begin
         if (mi_ff == MIW'(SW)) begin
            mbusy_in      = 1'b0;
            sts_mean_done = 1'b1;
            mean_in       = mneg_ff ? -$signed(mq_ff) : $signed(mq_ff);
         end else begin
            mi_in = mi_ff + MIW'(1);
            if (!mtry[CW]) begin
               mr_in = mtry;
               mq_in = {mq_ff[SW-2:0], 1'b1};
            end else begin
               mr_in = mshift;
               mq_in = {mq_ff[SW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else begin
         mbusy_ff <= mbusy_in;
      end
      mq_ff <= mq_in; mr_ff <= mr_in; mi_ff <= mi_in;
      mneg_ff <= mneg_in; mean_ff <= mean_in;
   end

   // second pass
   logic [CW-1:0]           pa_ff, pa_in;
   logic                    pv1_ff, pv2_ff, pv3_ff;
   logic signed [DW-1:0]    d_ff;
   logic [QW-1:0]           sq_ff, acc_ff, acc_in;
   logic [DW-1:0]           mag;
   logic [2*DW-1:0]         sqv;
   logic [QW:0]             accsum;

   assign pa_in        = cmd.pass_clr ? '0 : (cmd.pass_rd ? pa_ff + CW'(1) : pa_ff);
   assign sts_pass_end = cmd.pass_rd && (pa_ff + CW'(1) >= cnt_ff);
   assign mag          = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);
   assign sqv          = mag * mag;
   assign accsum       = {1'b0, acc_ff} + {1'b0, sq_ff};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.pass_clr) begin
         acc_in = '0;
      end else if (pv3_ff) begin
         acc_in = accsum[QW] ? '1 : accsum[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv1_ff <= 1'b0;
         pv2_ff <= 1'b0;
         pv3_ff <= 1'b0;
         pa_ff  <= '0;
      end else begin
         pv1_ff <= cmd.pass_rd;
         pv2_ff <= pv1_ff && (cmd.pass_add || cmd.pass_rd);
         pv3_ff <= pv2_ff;
         pa_ff  <= pa_in;
      end
      d_ff   <= DW'($signed(rd_data)) - DW'(mean_ff);
      sq_ff  <= QW'(sqv);
      acc_ff <= acc_in;
   end

   logic [AW-1:0] wr_addr, rd_addr;
   assign wr_addr = cnt_ff[AW-1:0];
   assign rd_addr = pa_ff[AW-1:0];

   smd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_wr),
      .wr_addr (wr_addr),
      .wr_data (sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // divide acc by n*n, restoring, one bit a cycle
   logic [NW-1:0]  nsq_ff;
   logic [QW-1:0]  q_ff, q_in;
   logic [NW:0]    r_ff, r_in, rsh, rtry;
   logic [6:0]     di_ff, di_in;
   logic           dbusy_ff, dbusy_in;

   assign rsh  = {r_ff[NW-1:0], q_ff[QW-1]};
   assign rtry = rsh - {1'b0, nsq_ff};

   always_comb begin
      q_in = q_ff; r_in = r_ff; di_in = di_ff; dbusy_in = dbusy_ff;
      sts_div_done = 1'b0;
      if (cmd.div_start) begin
         q_in = acc_ff; r_in = '0; di_in = '0; dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         if (di_ff == 7'(QW)) begin
            dbusy_in     = 1'b0;
            sts_div_done = 1'b1;
         end else begin
            di_in = di_ff + 7'd1;
            if (!rtry[NW]) begin
               r_in = rtry; q_in = {q_ff[QW-2:0], 1'b1};
            end else begin
               r_in = rsh;  q_in = {q_ff[QW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else begin
         dbusy_ff <= dbusy_in;
      end
      nsq_ff <= NW'(cnt_ff) * NW'(cnt_ff);
      q_ff <= q_in; r_ff <= r_in; di_ff <= di_in;
   end

   // integer square root, one bit pair a cycle
   logic [QW-1:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [QW-1:0] rb;
   logic          sbusy_ff, sbusy_in;

   assign rb = res_ff + bit_ff;

   always_comb begin
      x_in = x_ff; res_in = res_ff; bit_in = bit_ff; sbusy_in = sbusy_ff;
      sts_sqrt_done = 1'b0;
      if (cmd.sqrt_start) begin
         x_in = q_ff; res_in = '0; bit_in = QW'(1) << (QW - 2); sbusy_in = 1'b1;
      end else if (sbusy_ff) begin
         if (bit_ff == '0) begin
            sbusy_in      = 1'b0;
            sts_sqrt_done = 1'b1;
         end else begin
            bit_in = bit_ff >> 2;
            if (x_ff >= rb) begin
               x_in   = x_ff - rb;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else begin
         sbusy_ff <= sbusy_in;
      end
      x_ff <= x_in; res_ff <= res_in; bit_ff <= bit_in;
   end

   // result register
   logic [15:0] mean_o_ff, spread_o_ff;
   logic [10:0] count_o_ff;
   logic        ovf_o_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         mean_o_ff   <= 16'(mean_ff);
         spread_o_ff <= (res_ff > QW'(16'hFFFF)) ? 16'hFFFF : res_ff[15:0];
         count_o_ff  <= 11'(cnt_ff);
         ovf_o_ff    <= drop_ff;
      end
   end

   assign mean       = mean_o_ff;
   assign spread     = spread_o_ff;
   assign count      = count_o_ff;
   assign overflowed = ovf_o_ff;

endmodule

/* hw/rtl/sample_mean_and_deviation_top.sv */
// ----------------------------------------------------------------------------
// sample_mean_and_deviation_top
// Mean and standard error of the mean over a marked set of Q7.8 samples.
// ----------------------------------------------------------------------------
// Samples load one per cycle into a sample RAM while req_ready is high.
// After the last-marked sample the block runs the mean divider, the
// squared-deviation pass over the RAM, the 64-bit divide by n*n and the
// square root, then offers one result; no sample is taken until that result
// is accepted.
module sample_mean_and_deviation_top
   import smd_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_mean,
   output logic [15:0]            rsp_spread,
   output logic [10:0]            rsp_count,
   output logic                   rsp_overflowed
);

   smd_cmd_type cmd;
   smd_sts_type sts;

   smd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   smd_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .sample      (req_sample),
      .sample_take (req_valid && req_ready),
      .cmd         (cmd),
      .sts         (sts),
      .mean        (rsp_mean),
      .spread      (rsp_spread),
      .count       (rsp_count),
      .overflowed  (rsp_overflowed)
   );

endmodule
